>>> design/i2c_mbe_pkg.sv
// Shared types and constants of the I2C master byte engine.
`timescale 1ns / 1ps

package i2c_mbe_pkg;

    // Command codes carried in the opcode field
    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ_ACK  = 3'd3,
        OP_READ_NACK = 3'd4
    } opcode_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 4'd1;

    // Reset values of the configuration registers
    localparam logic [7:0]  PHASE_TICKS_RST = 8'd2;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd200;

    // Sequence step codes; meaning of the numbered steps depends on the command
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST       = 4'd1;
    localparam logic [STEP_W-1:0] STEP_READ_SCL_LO = 4'd2;
    localparam logic [STEP_W-1:0] STEP_BIT_SCL_HI  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_AFTER_BITS  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ACK_RELEASE = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ACK_WAIT    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ACK_SCL_LO  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ABORT_FIRST = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ABORT_LAST  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_COND_LAST   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_READ_LAST   = 4'd7;

    localparam logic [2:0] LAST_BIT = 3'd7;

    // Line selector of one bus phase
    localparam logic LINE_SCL = 1'b0;
    localparam logic LINE_SDA = 1'b1;

    // One tick request after classification
    typedef struct packed {
        logic       start;   // idle engine would take a command on this tick
        opcode_t    op;
        logic [7:0] tx;
        logic       sda;
    } tick_t;

    // Pin action of the current phase
    typedef struct packed {
        logic line;
        logic val;
        logic timed;         // low during the acknowledge wait
    } phase_t;

endpackage

>>> design/i2c_mbe_if.sv
// Channel interfaces of the I2C master byte engine: tick requests, results, configuration.
`timescale 1ns / 1ps

interface i2c_mbe_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, cmd_valid, opcode, tx_byte, sda_in, input ready);
    modport sink   (input valid, cmd_valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface i2c_mbe_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       ack_missing;

    modport source (output valid, scl_out, sda_out, busy_res, cmd_done, rx_byte, ack_missing,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, cmd_done, rx_byte, ack_missing,
                    output ready);
endinterface

interface i2c_mbe_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [i2c_mbe_pkg::CFG_IDX_W-1:0]  index;
    logic [i2c_mbe_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/i2c_mbe_front.sv
// Front stage: accept tick requests, classify the command, hand them to the queue.
`timescale 1ns / 1ps

module i2c_mbe_front (
    input  logic               clk,
    input  logic               rst_n,
    i2c_mbe_cmd_if.sink        cmd,
    output logic               push_valid,
    output i2c_mbe_pkg::tick_t push_data,
    input  logic               push_ready
);

    logic               valid_reg;
    i2c_mbe_pkg::tick_t tick_reg;
    i2c_mbe_pkg::tick_t tick_next;
    logic               push;
    logic               accept;

    assign push       = valid_reg && push_ready;
    assign cmd.ready  = !valid_reg || push_ready;
    assign accept     = cmd.valid && cmd.ready;
    assign push_valid = valid_reg;
    assign push_data  = tick_reg;

    // Classify: only a valid known opcode may start a command
    always_comb
    begin
        tick_next.start = cmd.cmd_valid && (cmd.opcode <= 3'(i2c_mbe_pkg::OP_READ_NACK));
        tick_next.op    = i2c_mbe_pkg::opcode_t'(cmd.opcode);
        tick_next.tx    = cmd.tx_byte;
        tick_next.sda   = cmd.sda_in;
    end

    // Hold one request until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= tick_next;
        end
    end

endmodule

>>> design/i2c_mbe_queue.sv
// Short request queue between the front stage and the bus engine.
`timescale 1ns / 1ps

module i2c_mbe_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  i2c_mbe_pkg::tick_t push_data,
    output logic               push_ready,
    output logic               pop_valid,
    output i2c_mbe_pkg::tick_t pop_data,
    input  logic               pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    i2c_mbe_pkg::tick_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/i2c_mbe_engine.sv
// Back end: bus phase sequencer, configuration registers and result register.
`timescale 1ns / 1ps

module i2c_mbe_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    input  i2c_mbe_pkg::tick_t pop_data,
    output logic               pop_ready,
    i2c_mbe_cfg_if.sink        cfg,
    i2c_mbe_res_if.source      res
);

    // Configuration
    logic [7:0]  phase_ticks_reg;
    logic [15:0] ack_timeout_reg;

    // Sequencer state
    i2c_mbe_pkg::opcode_t          cmd_reg, cmd_next;
    logic [i2c_mbe_pkg::STEP_W-1:0] step_reg, step_next;
    logic [7:0]  phase_cnt_reg, phase_cnt_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] timeout_cnt_reg, timeout_cnt_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_flag_reg, ack_flag_next;
    logic [7:0]  rx_latch_reg, rx_latch_next;

    // Result register
    logic        out_valid_reg;
    logic        done_reg, done_next;

    logic                 pop;
    logic                 run;
    logic                 phase_end;
    logic [7:0]           limit;
    logic [i2c_mbe_pkg::STEP_W-1:0] cur_step;
    i2c_mbe_pkg::phase_t  act;

    // Pin action of one step of one command
    function automatic i2c_mbe_pkg::phase_t phase_action(
        input i2c_mbe_pkg::opcode_t          op,
        input logic [i2c_mbe_pkg::STEP_W-1:0] s,
        input logic                          msb
    );
        i2c_mbe_pkg::phase_t a;
        a.line  = i2c_mbe_pkg::LINE_SCL;
        a.val   = 1'b0;
        a.timed = 1'b1;
        unique case (op)
            i2c_mbe_pkg::OP_START:
            begin
                unique case (s)
                    4'd1:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b1; end
                    4'd2:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    4'd3:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b0; end
                    4'd4:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                    default: ;
                endcase
            end
            i2c_mbe_pkg::OP_STOP:
            begin
                unique case (s)
                    4'd1:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                    4'd2:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b0; end
                    4'd3:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    4'd4:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b1; end
                    default: ;
                endcase
            end
            i2c_mbe_pkg::OP_WRITE:
            begin
                unique case (s)
                    4'd1:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                    4'd2:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = msb;  end
                    4'd3:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    4'd4:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                    4'd5:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b1; end
                    4'd6:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    4'd7:
                    begin
                        a.line  = i2c_mbe_pkg::LINE_SCL;
                        a.val   = 1'b1;
                        a.timed = 1'b0;
                    end
                    4'd8:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                    4'd9:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                    4'd10:   begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b0; end
                    4'd11:   begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    4'd12:   begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b1; end
                    default: ;
                endcase
            end
            default:
            begin
                // Read with ack or nack
                unique case (s)
                    4'd1:    begin a.line = i2c_mbe_pkg::LINE_SDA; a.val = 1'b1; end
                    4'd3:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    4'd5:
                    begin
                        a.line = i2c_mbe_pkg::LINE_SDA;
                        a.val  = (op == i2c_mbe_pkg::OP_READ_NACK);
                    end
                    4'd6:    begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b1; end
                    default: begin a.line = i2c_mbe_pkg::LINE_SCL; a.val = 1'b0; end
                endcase
            end
        endcase
        return a;
    endfunction

    assign pop_ready = !out_valid_reg || res.ready;
    assign pop       = pop_valid && pop_ready;
    assign cfg.ready = 1'b1;
    assign limit     = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;

    // Run one tick of the sequencer
    always_comb
    begin
        cmd_next         = cmd_reg;
        step_next        = step_reg;
        phase_cnt_next   = phase_cnt_reg;
        bit_cnt_next     = bit_cnt_reg;
        shift_next       = shift_reg;
        timeout_cnt_next = timeout_cnt_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        ack_flag_next    = ack_flag_reg;
        rx_latch_next    = rx_latch_reg;
        done_next        = 1'b0;
        run              = 1'b0;
        act              = '0;
        phase_end        = 1'b0;
        cur_step         = step_reg;

        if (pop)
        begin
            // Take a new command when idle
            if (step_reg == i2c_mbe_pkg::STEP_IDLE)
            begin
                if (pop_data.start)
                begin
                    cmd_next         = pop_data.op;
                    step_next        = i2c_mbe_pkg::STEP_FIRST;
                    phase_cnt_next   = '0;
                    bit_cnt_next     = '0;
                    timeout_cnt_next = '0;
                    if (pop_data.op == i2c_mbe_pkg::OP_WRITE)
                    begin
                        shift_next    = pop_data.tx;
                        ack_flag_next = 1'b0;
                    end
                    else
                    begin
                        shift_next = '0;
                    end
                    run = 1'b1;
                end
            end
            else
            begin
                run = 1'b1;
            end
        end

        if (run)
        begin
            cur_step = step_next;
            act = phase_action(cmd_next, cur_step, shift_next[7]);
            if (act.line == i2c_mbe_pkg::LINE_SCL)
            begin
                scl_next = act.val;
            end
            else
            begin
                sda_next = act.val;
            end

            if (!act.timed)
            begin
                // Acknowledge wait
                if (!pop_data.sda)
                begin
                    step_next      = i2c_mbe_pkg::STEP_ACK_SCL_LO;
                    phase_cnt_next = '0;
                end
                else if (timeout_cnt_next >= ack_timeout_reg)
                begin
                    ack_flag_next  = 1'b1;
                    step_next      = i2c_mbe_pkg::STEP_ABORT_FIRST;
                    phase_cnt_next = '0;
                end
                else
                begin
                    timeout_cnt_next = timeout_cnt_next + 16'd1;
                end
            end
            else if ({1'b0, phase_cnt_next} + 9'd1 < {1'b0, limit})
            begin
                phase_cnt_next = phase_cnt_next + 8'd1;
            end
            else
            begin
                phase_cnt_next = '0;
                phase_end      = 1'b1;
            end

            // Advance to the next phase
            if (phase_end)
            begin
                priority case (cmd_next)
                    i2c_mbe_pkg::OP_START, i2c_mbe_pkg::OP_STOP:
                    begin
                        if (cur_step >= i2c_mbe_pkg::STEP_COND_LAST)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            step_next = cur_step + 1'b1;
                        end
                    end
                    i2c_mbe_pkg::OP_WRITE:
                    begin
                        if (cur_step == i2c_mbe_pkg::STEP_BIT_SCL_HI)
                        begin
                            shift_next = {shift_next[6:0], 1'b0};
                            if (bit_cnt_next != i2c_mbe_pkg::LAST_BIT)
                            begin
                                bit_cnt_next = bit_cnt_next + 3'd1;
                                step_next    = i2c_mbe_pkg::STEP_FIRST;
                            end
                            else
                            begin
                                step_next = i2c_mbe_pkg::STEP_AFTER_BITS;
                            end
                        end
                        else
                        begin
                            if (cur_step == i2c_mbe_pkg::STEP_ACK_RELEASE)
                            begin
                                timeout_cnt_next = '0;
                            end
                            if (cur_step == i2c_mbe_pkg::STEP_ACK_SCL_LO
                                || cur_step >= i2c_mbe_pkg::STEP_ABORT_LAST)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                step_next = cur_step + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (cur_step == i2c_mbe_pkg::STEP_BIT_SCL_HI)
                        begin
                            shift_next = {shift_next[6:0], pop_data.sda};
                            if (bit_cnt_next != i2c_mbe_pkg::LAST_BIT)
                            begin
                                bit_cnt_next = bit_cnt_next + 3'd1;
                                step_next    = i2c_mbe_pkg::STEP_READ_SCL_LO;
                            end
                            else
                            begin
                                step_next = i2c_mbe_pkg::STEP_AFTER_BITS;
                            end
                        end
                        else if (cur_step >= i2c_mbe_pkg::STEP_READ_LAST)
                        begin
                            rx_latch_next = shift_next;
                            done_next     = 1'b1;
                        end
                        else
                        begin
                            step_next = cur_step + 1'b1;
                        end
                    end
                endcase
            end

            // Return to idle on completion
            if (done_next)
            begin
                step_next      = i2c_mbe_pkg::STEP_IDLE;
                phase_cnt_next = '0;
            end
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2c_mbe_pkg::PHASE_TICKS_RST;
            ack_timeout_reg <= i2c_mbe_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == i2c_mbe_pkg::CFG_PHASE_TICKS)
            begin
                phase_ticks_reg <= cfg.data[7:0];
            end
            else if (cfg.index == i2c_mbe_pkg::CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg.data;
            end
        end
    end

    // Update sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg         <= i2c_mbe_pkg::OP_START;
            step_reg        <= i2c_mbe_pkg::STEP_IDLE;
            phase_cnt_reg   <= '0;
            bit_cnt_reg     <= '0;
            shift_reg       <= '0;
            timeout_cnt_reg <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_flag_reg    <= 1'b0;
            rx_latch_reg    <= '0;
            out_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cmd_reg         <= cmd_next;
                step_reg        <= step_next;
                phase_cnt_reg   <= phase_cnt_next;
                bit_cnt_reg     <= bit_cnt_next;
                shift_reg       <= shift_next;
                timeout_cnt_reg <= timeout_cnt_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                ack_flag_reg    <= ack_flag_next;
                rx_latch_reg    <= rx_latch_next;
                done_reg        <= done_next;
                out_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_out     = scl_reg;
    assign res.sda_out     = sda_reg;
    assign res.busy_res    = (step_reg != i2c_mbe_pkg::STEP_IDLE);
    assign res.cmd_done    = done_reg;
    assign res.rx_byte     = rx_latch_reg;
    assign res.ack_missing = ack_flag_reg;

endmodule

>>> design/i2c_master_byte_engine.sv
// Path: an accepted tick request passes the front register, a queue slot
//   and the engine result register before its result shows.
// Throughput: one tick request in and out per cycle while res.ready is high.
// Reset: rst_n is asynchronous, active low; lines released high, engine idle,
//   phase_ticks 2, ack_timeout 200, queue empty.
`timescale 1ns / 1ps

module i2c_master_byte_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    i2c_mbe_cmd_if.sink   cmd,
    i2c_mbe_cfg_if.sink   cfg,
    i2c_mbe_res_if.source res
);

    logic               push_valid;
    logic               push_ready;
    i2c_mbe_pkg::tick_t push_data;
    logic               pop_valid;
    logic               pop_ready;
    i2c_mbe_pkg::tick_t pop_data;

    // Accept and classify tick requests
    i2c_mbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // Decouple front and back
    i2c_mbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Drive the bus phases
    i2c_mbe_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .cfg       (cfg),
        .res       (res)
    );

endmodule

>>> test/i2c_master_byte_engine_tb.sv
// Self-checking testbench of the I2C master byte engine: random bus ticks against a line predictor.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;
    import i2c_mbe_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned STALL_CYCLES = 400;
    localparam int unsigned SETTLE       = 8;

    // One bus tick request and the line state it leaves behind
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       cmd_done;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } line_state_t;

    logic clk = 1'b0;
    logic rst_n;

    i2c_mbe_cmd_if cmd_ch ();
    i2c_mbe_res_if res_ch ();
    i2c_mbe_cfg_if cfg_ch ();

    i2c_master_byte_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    // Stimulus and expectation stores
    tick_req_t   tick_req_q[$];
    line_state_t line_state_q[$];

    int unsigned ticks_sent;
    int unsigned ticks_taken;
    int unsigned gen_ticks;
    int unsigned err_cnt;
    int unsigned results_seen;
    int unsigned cycle_cnt;
    int unsigned cmd_seen[5];
    int unsigned timeouts_seen;
    int unsigned busy_offers;

    int unsigned drv_wait;
    int unsigned mon_wait;
    int unsigned hold_left;
    logic        hold_arm;
    bit          drv_idle_en;
    bit          mon_idle_en;

    // Predictor state: configuration and engine registers
    logic [7:0]  eng_pt;
    logic [15:0] eng_tmo_lim;
    logic [2:0]  eng_cmd;
    logic [4:0]  eng_step;
    logic [7:0]  eng_phase;
    logic [3:0]  eng_bit;
    logic [7:0]  eng_shift;
    logic [15:0] eng_tmo;
    logic        eng_scl;
    logic        eng_sda;
    logic        eng_nak;
    logic [7:0]  eng_rx;

    function automatic void engine_reset();
        eng_pt      = PHASE_TICKS_RST;
        eng_tmo_lim = ACK_TIMEOUT_RST;
        eng_cmd     = OP_START;
        eng_step    = 5'd0;
        eng_phase   = 8'd0;
        eng_bit     = 4'd0;
        eng_shift   = 8'd0;
        eng_tmo     = 16'd0;
        eng_scl     = 1'b1;
        eng_sda     = 1'b1;
        eng_nak     = 1'b0;
        eng_rx      = 8'd0;
    endfunction

    // Pin action of the current step; timed is low only in the acknowledge wait
    function automatic void phase_pins(output logic pin_sel, output logic pin_val,
                                       output logic timed);
        pin_sel = LINE_SCL;
        pin_val = 1'b0;
        timed   = 1'b1;
        case (eng_cmd)
            OP_START:
                case (eng_step)
                    5'd1: {pin_sel, pin_val} = {LINE_SDA, 1'b1};
                    5'd2: {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    5'd3: {pin_sel, pin_val} = {LINE_SDA, 1'b0};
                    default: {pin_sel, pin_val} = {LINE_SCL, 1'b0};
                endcase
            OP_STOP:
                case (eng_step)
                    5'd1: {pin_sel, pin_val} = {LINE_SCL, 1'b0};
                    5'd2: {pin_sel, pin_val} = {LINE_SDA, 1'b0};
                    5'd3: {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    5'd4: {pin_sel, pin_val} = {LINE_SDA, 1'b1};
                    default: {pin_sel, pin_val} = {LINE_SCL, 1'b0};
                endcase
            OP_WRITE:
                case (eng_step)
                    5'd2:  {pin_sel, pin_val} = {LINE_SDA, eng_shift[7]};
                    5'd3:  {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    5'd5:  {pin_sel, pin_val} = {LINE_SDA, 1'b1};
                    5'd6:  {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    5'd7:
                    begin
                        {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                        timed = 1'b0;
                    end
                    // abort: the four stop phases
                    5'd10: {pin_sel, pin_val} = {LINE_SDA, 1'b0};
                    5'd11: {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    5'd12: {pin_sel, pin_val} = {LINE_SDA, 1'b1};
                    default: {pin_sel, pin_val} = {LINE_SCL, 1'b0};
                endcase
            default:
                case (eng_step)
                    5'd1: {pin_sel, pin_val} = {LINE_SDA, 1'b1};
                    5'd3: {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    5'd5: {pin_sel, pin_val} = {LINE_SDA, eng_cmd == OP_READ_NACK};
                    5'd6: {pin_sel, pin_val} = {LINE_SCL, 1'b1};
                    default: {pin_sel, pin_val} = {LINE_SCL, 1'b0};
                endcase
        endcase
    endfunction

    // Advance one busy tick; return 1 when the command completes
    function automatic bit engine_tick(logic sda);
        logic        pin_sel;
        logic        pin_val;
        logic        timed;
        logic [4:0]  cur;
        int unsigned lim;
        cur = eng_step;
        phase_pins(pin_sel, pin_val, timed);
        if (pin_sel == LINE_SCL)
            eng_scl = pin_val;
        else
            eng_sda = pin_val;

        // acknowledge wait: low ends it, high past the limit aborts with a stop
        if (!timed)
        begin
            if (!sda)
            begin
                eng_step  = 5'd8;
                eng_phase = 8'd0;
            end
            else if (eng_tmo >= eng_tmo_lim)
            begin
                eng_nak   = 1'b1;
                eng_step  = 5'd9;
                eng_phase = 8'd0;
                timeouts_seen++;
            end
            else
                eng_tmo = eng_tmo + 16'd1;
            return 1'b0;
        end

        // hold the phase for its tick count
        lim = (eng_pt == 8'd0) ? 1 : eng_pt;
        if (int'(eng_phase) + 1 < lim)
        begin
            eng_phase = eng_phase + 8'd1;
            return 1'b0;
        end
        eng_phase = 8'd0;

        case (eng_cmd)
            OP_START, OP_STOP:
            begin
                if (cur >= 5'd4)
                    return 1'b1;
                eng_step = cur + 5'd1;
                return 1'b0;
            end
            OP_WRITE:
            begin
                if (cur == 5'd3)
                begin
                    eng_shift = eng_shift << 1;
                    if (eng_bit < LAST_BIT)
                    begin
                        eng_bit  = eng_bit + 4'd1;
                        eng_step = 5'd1;
                    end
                    else
                        eng_step = 5'd4;
                    return 1'b0;
                end
                if (cur == 5'd6)
                    eng_tmo = 16'd0;
                if (cur == 5'd8 || cur >= 5'd12)
                    return 1'b1;
                eng_step = cur + 5'd1;
                return 1'b0;
            end
            default:
            begin
                // sample SDA at the end of the high phase
                if (cur == 5'd3)
                begin
                    eng_shift = {eng_shift[6:0], sda};
                    if (eng_bit < LAST_BIT)
                    begin
                        eng_bit  = eng_bit + 4'd1;
                        eng_step = 5'd2;
                    end
                    else
                        eng_step = 5'd4;
                    return 1'b0;
                end
                if (cur >= 5'd7)
                begin
                    eng_rx = eng_shift;
                    return 1'b1;
                end
                eng_step = cur + 5'd1;
                return 1'b0;
            end
        endcase
    endfunction

    // Line state after one accepted tick request
    function automatic line_state_t predict_bus_tick(tick_req_t t);
        bit          done;
        line_state_t r;
        done = 1'b0;
        if (eng_step == 5'd0)
        begin
            if (t.cmd_valid && t.opcode <= OP_READ_NACK)
            begin
                eng_cmd   = t.opcode;
                eng_step  = 5'd1;
                eng_phase = 8'd0;
                eng_bit   = 4'd0;
                eng_tmo   = 16'd0;
                if (t.opcode == OP_WRITE)
                begin
                    eng_shift = t.tx_byte;
                    eng_nak   = 1'b0;
                end
                else
                    eng_shift = 8'd0;
                cmd_seen[t.opcode]++;
                done = engine_tick(t.sda_in);
            end
        end
        else
        begin
            if (t.cmd_valid)
                busy_offers++;
            done = engine_tick(t.sda_in);
        end
        if (done)
        begin
            eng_step  = 5'd0;
            eng_phase = 8'd0;
        end
        r.scl_out     = eng_scl;
        r.sda_out     = eng_sda;
        r.busy_res    = (eng_step != 5'd0);
        r.cmd_done    = done;
        r.rx_byte     = eng_rx;
        r.ack_missing = eng_nak;
        return r;
    endfunction

    function automatic int unsigned draw_wait(bit en);
        return en ? $urandom_range(0, 19) : 0;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Drive tick requests from the pending queue and predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        tick_req_t nxt;
        tick_req_t taken;
        if (!rst_n)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.cmd_valid <= 1'b0;
            cmd_ch.opcode    <= OP_START;
            cmd_ch.tx_byte   <= 8'd0;
            cmd_ch.sda_in    <= 1'b1;
            drv_wait         <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken.cmd_valid = cmd_ch.cmd_valid;
                taken.opcode    = cmd_ch.opcode;
                taken.tx_byte   = cmd_ch.tx_byte;
                taken.sda_in    = cmd_ch.sda_in;
                line_state_q.push_back(predict_bus_tick(taken));
                ticks_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (drv_wait != 0)
                begin
                    drv_wait     <= drv_wait - 1;
                    cmd_ch.valid <= 1'b0;
                end
                else if (tick_req_q.size() != 0)
                begin
                    nxt = tick_req_q.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.cmd_valid <= nxt.cmd_valid;
                    cmd_ch.opcode    <= nxt.opcode;
                    cmd_ch.tx_byte   <= nxt.tx_byte;
                    cmd_ch.sda_in    <= nxt.sda_in;
                    drv_wait         <= draw_wait(drv_idle_en);
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Count down a long receiver hold-off once armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= STALL_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Accept results with random back-pressure and compare with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        line_state_t want;
        int unsigned nxt_wait;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            mon_wait     <= 0;
        end
        else
        begin
            nxt_wait = mon_wait;
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (line_state_q.size() == 0)
                begin
                    $error("result with no tick request pending");
                    err_cnt++;
                end
                else
                begin
                    want = line_state_q.pop_front();
                    check_field("scl_out", want.scl_out, res_ch.scl_out);
                    check_field("sda_out", want.sda_out, res_ch.sda_out);
                    check_field("busy_res", want.busy_res, res_ch.busy_res);
                    check_field("cmd_done", want.cmd_done, res_ch.cmd_done);
                    check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
                    check_field("ack_missing", want.ack_missing, res_ch.ack_missing);
                end
                nxt_wait = draw_wait(mon_idle_en);
            end
            else if (mon_wait != 0)
                nxt_wait = mon_wait - 1;
            mon_wait     <= nxt_wait;
            res_ch.ready <= (nxt_wait == 0) && (hold_left == 0);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("i2c_master_byte_engine_tb: FAIL");
            $finish;
        end
    end

    task automatic push_tick(tick_req_t t);
        tick_req_q.push_back(t);
        ticks_sent++;
    endtask

    // Idle ticks: nothing offered, or an undefined opcode that must be ignored
    task automatic idle_ticks(int unsigned n);
        tick_req_t t;
        repeat (n)
        begin
            t.cmd_valid = 1'($urandom_range(0, 1));
            t.opcode    = 3'($urandom_range(5, 7));
            t.tx_byte   = 8'($urandom);
            t.sda_in    = 1'($urandom_range(0, 1));
            push_tick(t);
        end
    endtask

    // Queue one command and the exact number of ticks it stays busy.
    // highs: high SDA samples before the acknowledge; above the limit it times out.
    task automatic issue_command(opcode_t op, logic [7:0] tx, int unsigned highs, bit noisy);
        tick_req_t   t;
        int unsigned pt;
        int unsigned dur;
        int unsigned wait_at;
        int unsigned wait_hi;
        bit          acked;
        pt      = (eng_pt == 8'd0) ? 1 : eng_pt;
        acked   = (highs <= eng_tmo_lim);
        wait_at = 27 * pt;
        wait_hi = acked ? highs : eng_tmo_lim + 1;
        case (op)
            OP_WRITE: dur = acked ? wait_at + highs + 1 + pt : wait_at + wait_hi + 4 * pt;
            OP_READ_ACK, OP_READ_NACK: dur = 21 * pt;
            default: dur = 4 * pt;
        endcase
        for (int unsigned i = 0; i < dur; i++)
        begin
            if (i == 0)
            begin
                t.cmd_valid = 1'b1;
                t.opcode    = op;
                t.tx_byte   = tx;
            end
            else
            begin
                // commands offered while busy must be ignored
                t.cmd_valid = noisy && ($urandom_range(0, 3) == 0);
                t.opcode    = 3'($urandom_range(0, 7));
                t.tx_byte   = 8'($urandom);
            end
            if (op == OP_WRITE && i >= wait_at && i < wait_at + wait_hi)
                t.sda_in = 1'b1;
            else if (op == OP_WRITE && acked && i == wait_at + wait_hi)
                t.sda_in = 1'b0;
            else
                t.sda_in = 1'($urandom_range(0, 1));
            push_tick(t);
        end
        gen_ticks += dur;
    endtask

    // Offer a command and only its first n ticks; the rest runs after the queue drains
    task automatic partial_command(opcode_t op, int unsigned n);
        tick_req_t t;
        for (int unsigned i = 0; i < n; i++)
        begin
            t.cmd_valid = (i == 0);
            t.opcode    = op;
            t.tx_byte   = 8'($urandom);
            t.sda_in    = 1'($urandom_range(0, 1));
            push_tick(t);
        end
        gen_ticks += n;
    endtask

    function automatic int unsigned rand_highs();
        int unsigned lim;
        lim = eng_tmo_lim;
        if ($urandom_range(0, 7) == 0)
            return lim + 1;
        return $urandom_range(0, (lim < 3) ? lim : 3);
    endfunction

    // Mostly framed transfers with random content; the rest is loose commands and noise
    task automatic random_transfer();
        int unsigned n;
        if ($urandom_range(0, 6) != 0)
        begin
            issue_command(OP_START, 8'($urandom), 0, 1'b1);
            idle_ticks($urandom_range(0, 2));
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                if ($urandom_range(0, 2) != 0)
                    issue_command(OP_WRITE, 8'($urandom), rand_highs(), 1'b1);
                else if ($urandom_range(0, 1) != 0)
                    issue_command(OP_READ_ACK, 8'($urandom), 0, 1'b1);
                else
                    issue_command(OP_READ_NACK, 8'($urandom), 0, 1'b1);
                idle_ticks($urandom_range(0, 2));
            end
            issue_command(OP_STOP, 8'($urandom), 0, 1'b1);
        end
        else
            issue_command(opcode_t'($urandom_range(0, 4)), 8'($urandom), rand_highs(), 1'b1);
        idle_ticks($urandom_range(0, 3));
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_PHASE_TICKS)
            eng_pt = val[7:0];
        else
            eng_tmo_lim = val;
    endtask

    // Hold until every request is taken and every result has arrived, then settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (ticks_taken != ticks_sent || line_state_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(logic [7:0] pt, logic [15:0] tmo, int unsigned n,
                                bit drv_en, bit mon_en, bit stall);
        int unsigned start_ticks;
        cfg_write(CFG_PHASE_TICKS, {8'd0, pt});
        cfg_write(CFG_ACK_TIMEOUT, tmo);
        drv_idle_en = drv_en;
        mon_idle_en = mon_en;
        start_ticks = gen_ticks;
        while (gen_ticks - start_ticks < n)
            random_transfer();
        // long receiver hold-off while the sender keeps offering
        if (stall)
        begin
            hold_arm <= 1'b1;
            @(posedge clk);
            hold_arm <= 1'b0;
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd_valid = 1'b0;
        cmd_ch.opcode    = OP_START;
        cmd_ch.tx_byte   = 8'd0;
        cmd_ch.sda_in    = 1'b1;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_PHASE_TICKS;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        hold_arm         = 1'b0;
        drv_idle_en      = 1'b1;
        mon_idle_en      = 1'b1;
        cycle_cnt        = 0;
        engine_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: full transfer, byte extremes, late ack, ignored opcodes
        issue_command(OP_START, 8'h00, 0, 1'b0);
        idle_ticks(3);
        issue_command(OP_WRITE, 8'hFF, 0, 1'b0);
        issue_command(OP_WRITE, 8'h00, 5, 1'b1);
        issue_command(OP_READ_ACK, 8'h00, 0, 1'b1);
        issue_command(OP_READ_NACK, 8'hFF, 0, 1'b0);
        issue_command(OP_STOP, 8'h00, 0, 1'b1);
        idle_ticks(4);
        wait_drained();

        // Zero phase ticks and zero timeout: first high sample aborts
        cfg_write(CFG_PHASE_TICKS, 16'd0);
        cfg_write(CFG_ACK_TIMEOUT, 16'd0);
        issue_command(OP_START, 8'h00, 0, 1'b0);
        issue_command(OP_WRITE, 8'h3C, 1, 1'b1);
        issue_command(OP_WRITE, 8'hC3, 0, 1'b0);
        issue_command(OP_READ_NACK, 8'h00, 0, 1'b1);
        issue_command(OP_STOP, 8'h00, 0, 1'b0);
        wait_drained();

        // Longest phase past its first phase end, then shorten it; longest timeout
        cfg_write(CFG_PHASE_TICKS, 16'd255);
        cfg_write(CFG_ACK_TIMEOUT, 16'd65535);
        partial_command(OP_START, 260);
        wait_drained();
        cfg_write(CFG_PHASE_TICKS, 16'd1);
        idle_ticks(4);
        issue_command(OP_WRITE, 8'h5A, 40, 1'b1);
        issue_command(OP_READ_ACK, 8'h00, 0, 1'b0);
        wait_drained();

        // Random phases over several settings and idling mixes
        random_phase(8'd1, 16'd1, 30, 1'b1, 1'b1, 1'b0);
        random_phase(8'd1, 16'd4, 30, 1'b0, 1'b1, 1'b1);
        random_phase(8'd2, 16'd3, 30, 1'b0, 1'b0, 1'b0);
        random_phase(8'd4, 16'd0, 30, 1'b1, 1'b1, 1'b0);
        random_phase(8'($urandom_range(1, 3)), 16'($urandom_range(1, 12)), 30,
                     1'b1, 1'b0, 1'b0);

        $display("Ran %0d bus ticks: %0d start, %0d stop, %0d write, %0d read-ack, %0d read-nack",
                 ticks_taken, cmd_seen[OP_START], cmd_seen[OP_STOP], cmd_seen[OP_WRITE],
                 cmd_seen[OP_READ_ACK], cmd_seen[OP_READ_NACK]);
        $display("%0d acknowledge timeouts, %0d commands offered while busy, %0d results checked",
                 timeouts_seen, busy_offers, results_seen);
        if (err_cnt == 0)
            $display("i2c_master_byte_engine_tb: PASS");
        else
            $display("i2c_master_byte_engine_tb: FAIL");
        $finish;
    end

endmodule
